// ===== rtl/bdeq_pkg.sv =====
// shared constants, action codes and controller command type for the deque
package bdeq_pkg;

  // ring store geometry
  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned ItemW      = 16;
  localparam int unsigned OutItemW   = ItemW + 1;

  // occupancy and capacity hold values up to the store depth itself
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned CapW       = 11;
  localparam logic [CapW-1:0] CapReset = CapW'(StoreDepth);
  localparam logic [CntW-1:0] CntMax   = CntW'(StoreDepth);

  // action field width
  localparam int unsigned ActW = 3;

  // action codes
  typedef enum logic [ActW-1:0] {
    ACT_QUERY     = 3'd0,
    ACT_INS_FRONT = 3'd1,
    ACT_INS_REAR  = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_REAR  = 3'd4
  } action_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic exec;  // apply the accepted item to pointer, count and store
    logic rd;    // read front and rear entries of the store
    logic load;  // build the result and load the output register
  } cmd_t;

endpackage

// ===== rtl/bdeq_intf.sv =====
// valid/ready channel interfaces for requests and results

// request channel: one action per item
interface bdeq_req_if;
  logic                          valid;
  logic                          ready;
  logic [bdeq_pkg::ActW-1:0]     action;
  logic [bdeq_pkg::ItemW-1:0]    data_in;

  modport source (output valid, action, data_in, input ready);
  modport sink   (input valid, action, data_in, output ready);
endinterface

// result channel: outcome and queue shape after the step
interface bdeq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [bdeq_pkg::OutItemW-1:0] front_item;
  logic signed [bdeq_pkg::OutItemW-1:0] rear_item;
  logic                              empty_now;
  logic                              full_now;

  modport source (output valid, ok, front_item, rear_item, empty_now, full_now,
                  input ready);
  modport sink   (input valid, ok, front_item, rear_item, empty_now, full_now,
                  output ready);
endinterface

// ===== rtl/bdeq_ctrl.sv =====
// controller state machine sequencing execute, store read and result load
module bdeq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bdeq_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_LOAD = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // output register can take a new result when empty or being drained
  assign out_free = !out_valid_q || out_ready_i;

  // commands
  always_comb begin
    cmd_o      = '0;
    cmd_o.exec = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.rd   = (state_q == ST_READ);
    cmd_o.load = (state_q == ST_LOAD) && out_free;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a result waiting and not taken keeps the controller in the load state
  a_load_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && out_valid_q && !out_ready_i) |=> (state_q == ST_LOAD))
    else $error("load state left while output register was blocked");

  // an accepted item always reaches the store read in the next cycle
  a_exec_then_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> cmd_o.rd)
    else $error("store read did not follow execute");

  // a new result is only shown after a load
  a_valid_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.load))
    else $error("output valid rose without a load");

endmodule

// ===== rtl/bdeq_dp.sv =====
// datapath: ring store, head pointer, occupancy, capacity and result register
module bdeq_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bdeq_pkg::cmd_t                     cmd_i,
  input  logic                               cfg_we_i,
  input  logic [bdeq_pkg::CapW-1:0]          cfg_wdata_i,
  input  logic [bdeq_pkg::ActW-1:0]          action_i,
  input  logic [bdeq_pkg::ItemW-1:0]         data_in_i,
  output logic                               ok_o,
  output logic signed [bdeq_pkg::OutItemW-1:0] front_item_o,
  output logic signed [bdeq_pkg::OutItemW-1:0] rear_item_o,
  output logic                               empty_now_o,
  output logic                               full_now_o
);

  logic [bdeq_pkg::ItemW-1:0] mem [bdeq_pkg::StoreDepth];

  logic [bdeq_pkg::AddrW-1:0] head_q, head_d;
  logic [bdeq_pkg::CntW-1:0]  occ_q, occ_d;
  logic [bdeq_pkg::CapW-1:0]  cap_q;
  logic                       ok_q, ok_d;

  logic [bdeq_pkg::CntW-1:0]  eff_cap;
  logic                       full, empty;
  logic                       we;
  logic [bdeq_pkg::AddrW-1:0] waddr;
  logic [bdeq_pkg::AddrW-1:0] rear_addr;
  logic [bdeq_pkg::ItemW-1:0] rd_front_q, rd_rear_q;

  logic                               res_ok_q;
  logic signed [bdeq_pkg::OutItemW-1:0] res_front_q, res_rear_q;
  logic                               res_empty_q, res_full_q;

  // capacity clamped to 1..store depth
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = bdeq_pkg::CntW'(1);
    end else if (cap_q > bdeq_pkg::CapW'(bdeq_pkg::StoreDepth)) begin
      eff_cap = bdeq_pkg::CntMax;
    end else begin
      eff_cap = bdeq_pkg::CntW'(cap_q);
    end
  end

  assign full  = (occ_q >= eff_cap);
  assign empty = (occ_q == '0);

  // execute one action
  always_comb begin
    head_d = head_q;
    occ_d  = occ_q;
    ok_d   = 1'b0;
    we     = 1'b0;
    waddr  = head_q;
    case (bdeq_pkg::action_e'(action_i))
      bdeq_pkg::ACT_QUERY: begin
        ok_d = 1'b1;
      end
      bdeq_pkg::ACT_INS_FRONT: begin
        ok_d = !full;
        if (!full) begin
          head_d = head_q - bdeq_pkg::AddrW'(1);
          waddr  = head_q - bdeq_pkg::AddrW'(1);
          we     = 1'b1;
          occ_d  = occ_q + bdeq_pkg::CntW'(1);
        end
      end
      bdeq_pkg::ACT_INS_REAR: begin
        ok_d = !full;
        if (!full) begin
          // not full means occupancy is below the depth and fits an address
          waddr = head_q + occ_q[bdeq_pkg::AddrW-1:0];
          we    = 1'b1;
          occ_d = occ_q + bdeq_pkg::CntW'(1);
        end
      end
      bdeq_pkg::ACT_DEL_FRONT: begin
        ok_d = !empty;
        if (!empty) begin
          head_d = head_q + bdeq_pkg::AddrW'(1);
          occ_d  = occ_q - bdeq_pkg::CntW'(1);
        end
      end
      bdeq_pkg::ACT_DEL_REAR: begin
        ok_d = !empty;
        if (!empty) begin
          occ_d = occ_q - bdeq_pkg::CntW'(1);
        end
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // pointer, count, ok flag and capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      occ_q  <= '0;
      ok_q   <= 1'b0;
      cap_q  <= bdeq_pkg::CapReset;
    end else begin
      if (cmd_i.exec) begin
        head_q <= head_d;
        occ_q  <= occ_d;
        ok_q   <= ok_d;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // rear entry sits occupancy minus one past the head, wrapping around
  assign rear_addr = head_q + occ_q[bdeq_pkg::AddrW-1:0] - bdeq_pkg::AddrW'(1);

  // ring store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && we) begin
      mem[waddr] <= data_in_i;
    end
    if (cmd_i.rd) begin
      rd_front_q <= mem[head_q];
      rd_rear_q  <= mem[rear_addr];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_ok_q    <= ok_q;
      res_front_q <= empty ? '1 : $signed({1'b0, rd_front_q});
      res_rear_q  <= empty ? '1 : $signed({1'b0, rd_rear_q});
      res_empty_q <= empty;
      res_full_q  <= full;
    end
  end

  assign ok_o         = res_ok_q;
  assign front_item_o = res_front_q;
  assign rear_item_o  = res_rear_q;
  assign empty_now_o  = res_empty_q;
  assign full_now_o   = res_full_q;

  // occupancy never exceeds the store depth
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= bdeq_pkg::CntMax)
    else $error("occupancy above store depth");

  // a refused or undefined action leaves head and occupancy alone
  a_refused_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && !ok_d) |=> ($stable(head_q) && $stable(occ_q)))
    else $error("refused action changed queue state");

  // one step moves occupancy by at most one
  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |=> (occ_q == $past(occ_q) || occ_q == $past(occ_q) + bdeq_pkg::CntW'(1)
                    || occ_q == $past(occ_q) - bdeq_pkg::CntW'(1)))
    else $error("occupancy jumped by more than one");

endmodule

// ===== rtl/bounded_double_ended_queue_unit.sv =====
// top level of the bounded double-ended queue: controller plus datapath
//
//  channel   direction  handshake          payload
//  req_i     in         valid/ready        action, data_in
//  rsp_o     out        valid/ready        ok, front_item, rear_item, empty_now, full_now
//  cfg       in         cfg_we_i (no wait) cfg_wdata_i = capacity
//
// each item passes through three steps: execute (store write and pointer update),
// store read of the front and rear entries, and load of the output register.
// the two-port read of the ring store comes as its own step after the write.
// the output register holds a finished result while the next item is taken.
// a stalled result holds the controller in its load state until taken.
// reset clears pointer, count, capacity (to 1024) and handshake state; the
// store itself needs no clearing since only written entries are read.
module bounded_double_ended_queue_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bdeq_pkg::CapW-1:0]   cfg_wdata_i,
  bdeq_req_if.sink                    req_i,
  bdeq_rsp_if.source                  rsp_o
);

  bdeq_pkg::cmd_t cmd;

  // control
  bdeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // storage and result path
  bdeq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .action_i     (req_i.action),
    .data_in_i    (req_i.data_in),
    .ok_o         (rsp_o.ok),
    .front_item_o (rsp_o.front_item),
    .rear_item_o  (rsp_o.rear_item),
    .empty_now_o  (rsp_o.empty_now),
    .full_now_o   (rsp_o.full_now)
  );

endmodule

// ===== dv/tb.sv =====
// testbench for the bounded double-ended queue unit
`timescale 1ns / 1ps

module tb;
  import bdeq_pkg::*;

  // run limits and pacing
  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned MaxWait      = 12;
  localparam int unsigned ShownErrors  = 10;

  // action codes past the defined set
  localparam int unsigned ActUndefLo = int'(ACT_DEL_REAR) + 1;
  localparam int unsigned ActUndefHi = (1 << ActW) - 1;

  // one result item as seen on the result channel
  typedef struct packed {
    logic                ok;
    logic [OutItemW-1:0] front;
    logic [OutItemW-1:0] rear;
    logic                empty;
    logic                full;
  } deque_view_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CapW-1:0] cfg_wdata;

  bdeq_req_if req_ch ();
  bdeq_rsp_if rsp_ch ();

  bounded_double_ended_queue_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  // shadow copy of the deque state
  logic [ItemW-1:0] shadow_ring [StoreDepth];
  logic [AddrW-1:0] shadow_head;
  int unsigned      shadow_count;
  logic [CapW-1:0]  shadow_cap;

  deque_view_t outcomes_due [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned cycle_count;
  bit          send_gaps;
  bit          take_stalls;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one action to the shadow deque and return the view after it
  function automatic deque_view_t deque_apply(logic [ActW-1:0] act, logic [ItemW-1:0] item);
    int unsigned lim;
    logic        was_full;
    logic        was_empty;
    deque_view_t v;
    lim = (shadow_cap == '0) ? 1 : ((shadow_cap > StoreDepth) ? StoreDepth : shadow_cap);
    was_full  = shadow_count >= lim;
    was_empty = shadow_count == 0;
    v = '0;
    case (act)
      ACT_QUERY: v.ok = 1'b1;
      ACT_INS_FRONT: begin
        v.ok = !was_full;
        if (v.ok) begin
          shadow_head = shadow_head - 1'b1;
          shadow_ring[shadow_head] = item;
          shadow_count++;
        end
      end
      ACT_INS_REAR: begin
        v.ok = !was_full;
        if (v.ok) begin
          shadow_ring[shadow_head + AddrW'(shadow_count)] = item;
          shadow_count++;
        end
      end
      ACT_DEL_FRONT: begin
        v.ok = !was_empty;
        if (v.ok) begin
          shadow_head = shadow_head + 1'b1;
          shadow_count--;
        end
      end
      ACT_DEL_REAR: begin
        v.ok = !was_empty;
        if (v.ok) shadow_count--;
      end
      default: v.ok = 1'b0;
    endcase
    v.empty = shadow_count == 0;
    v.full  = shadow_count >= lim;
    if (v.empty) begin
      v.front = '1;
      v.rear  = '1;
    end else begin
      v.front = {1'b0, shadow_ring[shadow_head]};
      v.rear  = {1'b0, shadow_ring[shadow_head + AddrW'(shadow_count - 1)]};
    end
    return v;
  endfunction

  // random action with a given share of inserts
  function automatic logic [ActW-1:0] pick_action(int unsigned ins_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return $urandom_range(0, 1) ? ACT_INS_FRONT : ACT_INS_REAR;
    if (r < 90) return $urandom_range(0, 1) ? ACT_DEL_FRONT : ACT_DEL_REAR;
    if (r < 96) return ACT_QUERY;
    return ActW'($urandom_range(ActUndefLo, ActUndefHi));
  endfunction

  // random data with the extremes now and then
  function automatic logic [ItemW-1:0] pick_data();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return ItemW'($urandom);
    endcase
  endfunction

  // send one request item; entered and left at a falling edge
  task automatic push_item(input logic [ActW-1:0] act, input logic [ItemW-1:0] item);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, MaxWait) : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.action  <= act;
    req_ch.data_in <= item;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    outcomes_due.insert(outcomes_due.size(), deque_apply(act, item));
    @(negedge clk);
  endtask

  // hold off the sender until every outcome is back
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (outcomes_due.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // capacity write, only while the unit is idle
  task automatic write_capacity(input logic [CapW-1:0] cap);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we     <= 1'b0;
    shadow_cap  = cap;
  endtask

  // result channel ready with random stalls
  initial begin : result_taker
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = take_stalls ? $urandom_range(0, MaxWait) : 0;
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  // compare each result item with the oldest outcome due
  always @(posedge clk) begin : result_check
    deque_view_t want;
    deque_view_t got;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got.ok    = rsp_ch.ok;
      got.front = rsp_ch.front_item;
      got.rear  = rsp_ch.rear_item;
      got.empty = rsp_ch.empty_now;
      got.full  = rsp_ch.full_now;
      if (outcomes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownErrors)
          $display("result %0d arrived with no request outstanding", results_seen);
      end else begin
        want = outcomes_due[0];
        outcomes_due.delete(0);
        if (got.ok !== want.ok || got.front !== want.front || got.rear !== want.rear ||
            got.empty !== want.empty || got.full !== want.full) begin
          mismatches++;
          if (mismatches <= ShownErrors) begin
            $display("result %0d: expected ok=%0b front=%0d rear=%0d empty=%0b full=%0b",
                     results_seen, want.ok, $signed(want.front), $signed(want.rear),
                     want.empty, want.full);
            $display("result %0d: got      ok=%0b front=%0d rear=%0d empty=%0b full=%0b",
                     results_seen, got.ok, $signed(got.front), $signed(got.rear),
                     got.empty, got.full);
          end
        end
      end
      results_seen++;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // empty deque right after reset, at reset capacity
  task automatic test_after_reset();
    push_item(ACT_QUERY, '0);
    push_item(ACT_DEL_FRONT, '1);
    push_item(ACT_DEL_REAR, '0);
    push_item(ActW'(ActUndefLo), '1);
  endtask

  // capacity zero acts as a single slot
  task automatic test_single_slot();
    settle();
    write_capacity('0);
    push_item(ACT_INS_REAR, '1);
    push_item(ACT_INS_FRONT, '0);
    push_item(ActW'(ActUndefHi), 16'h1234);
    push_item(ACT_DEL_REAR, '0);
    push_item(ACT_DEL_FRONT, '0);
    push_item(ACT_INS_FRONT, '0);
    push_item(ACT_DEL_FRONT, '1);
  endtask

  // capacity dropped under the current count
  task automatic test_shrink_below_count();
    settle();
    write_capacity(11'd3);
    push_item(ACT_INS_FRONT, 16'h5555);
    push_item(ACT_INS_REAR, 16'hAAAA);
    push_item(ACT_INS_FRONT, '0);
    push_item(ACT_INS_REAR, '1);
    settle();
    write_capacity(11'd1);
    push_item(ACT_INS_REAR, 16'h0F0F);
    push_item(ACT_DEL_FRONT, '0);
    push_item(ACT_DEL_REAR, '0);
    push_item(ACT_QUERY, '0);
    push_item(ACT_DEL_FRONT, '0);
  endtask

  // one random phase at a fixed capacity
  task automatic run_phase(input logic [CapW-1:0] cap, input int unsigned ins_pct,
                           input int unsigned n, input bit gaps, input bit stalls);
    settle();
    write_capacity(cap);
    send_gaps   = gaps;
    take_stalls = stalls;
    for (int unsigned i = 0; i < n; i++) begin
      // sender waits for the unit to drain halfway through
      if (i == n / 2) settle();
      push_item(pick_action(ins_pct), pick_data());
    end
  endtask

  // random mixes at a range of capacities, one above the store depth, filling and draining in turn
  task automatic test_random_mix();
    run_phase(11'd1, 50, 65, 1'b1, 1'b1);
    run_phase(11'd2, 70, 65, 1'b1, 1'b0);
    run_phase(11'd5, 25, 65, 1'b0, 1'b1);
    run_phase(11'd0, 60, 65, 1'b1, 1'b1);
    run_phase(11'd17, 80, 65, 1'b0, 1'b0);
    run_phase(11'd64, 85, 70, 1'b1, 1'b1);
    run_phase(11'd3, 20, 60, 1'b1, 1'b1);
    run_phase(11'd1500, 45, 60, 1'b1, 1'b0);
  endtask

  // fill the whole store, then work at and around full
  task automatic test_deep_fill();
    int unsigned n;
    settle();
    write_capacity('1);
    send_gaps   = 1'b1;
    take_stalls = 1'b1;
    n = 0;
    while (shadow_count < StoreDepth) begin
      // long run with no gaps to keep the fill short
      if (n == 150) begin
        send_gaps   = 1'b0;
        take_stalls = 1'b0;
      end
      push_item(pick_action(88), pick_data());
      n++;
    end
    send_gaps   = 1'b1;
    take_stalls = 1'b1;
    repeat (40) push_item(pick_action(45), pick_data());
    settle();
    write_capacity(CapReset);
    repeat (20) push_item(pick_action(60), pick_data());
    settle();
    write_capacity(11'd10);
    repeat (20) push_item(pick_action(50), pick_data());
  endtask

  // reset, tests in turn, final verdict
  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_ch.valid   = 1'b0;
    req_ch.action  = ACT_QUERY;
    req_ch.data_in = '0;
    shadow_head    = '0;
    shadow_count   = 0;
    shadow_cap     = CapReset;
    mismatches     = 0;
    results_seen   = 0;
    cycle_count    = 0;
    send_gaps      = 1'b1;
    take_stalls    = 1'b1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_after_reset();
    test_single_slot();
    test_shrink_below_count();
    test_random_mix();
    test_deep_fill();

    settle();
    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
